FILE: hw/rtl/gcm_pkg.sv
`timescale 1ns / 1ps

package gcm_pkg;

    // Gradient size; only the first STOP_COUNT stops and widths take part.
    localparam int STOP_COUNT    = 4;
    localparam int CHANNEL_COUNT = 4;

    // Register slots are fixed by the register map.
    localparam int REG_SLOTS = 4;
    localparam int SLOT_W    = $clog2(REG_SLOTS);

    localparam int LEVEL_W  = 17;
    localparam int Q15_W    = 16;
    localparam int WIDTH_W  = 16;
    localparam int COLOUR_W = 32;
    localparam int CHAN_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Running sum of widths never wraps.
    localparam int SUM_W = WIDTH_W + $clog2(REG_SLOTS);

    // Divider: numerator 510*d + w, denominator 2*w, quotient 0..255.
    localparam int NUM_W     = WIDTH_W + 9;
    localparam int DEN_W     = WIDTH_W + 1;
    localparam int QUO_W     = CHAN_W;
    localparam int DIV_STEP  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;

    // Stages from input to output register: two select, divider, two blend.
    localparam int PIPE_DEPTH = 2 + DIV_STAGES + 2;

    localparam logic [Q15_W-1:0]  ONE_Q15    = 16'h8000;
    localparam logic [CHAN_W-1:0] BYTE_MAX   = 8'hFF;
    localparam logic [15:0]       HALF_ROUND = 16'h0080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOUR_A = 3'd0,
        CFG_COLOUR_B = 3'd1,
        CFG_COLOUR_C = 3'd2,
        CFG_COLOUR_D = 3'd3,
        CFG_WIDTH_A  = 3'd4,
        CFG_WIDTH_B  = 3'd5,
        CFG_WIDTH_C  = 3'd6,
        CFG_WIDTH_D  = 3'd7
    } t_cfg_idx;

    typedef logic [REG_SLOTS-1:0][COLOUR_W-1:0]     t_colour_arr;
    typedef logic [REG_SLOTS-1:0][WIDTH_W-1:0]      t_width_arr;
    typedef logic [CHANNEL_COUNT-1:0][CHAN_W-1:0]   t_pixel;

    // Side information that rides along with the division.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_div_tag;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        t_div_tag         tag;
    } t_div_req;

endpackage

FILE: hw/rtl/gcm_seg_select.sv
`timescale 1ns / 1ps

module gcm_seg_select import gcm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [LEVEL_W-1:0] i_level,
    input  t_width_arr                i_width,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_div_req                  o_req
);

    // Stage A: clamp and segment search.
    logic                 r_a_v;
    logic [Q15_W-1:0]     r_a_lvl;
    logic [SUM_W-1:0]     r_a_start;
    logic [WIDTH_W-1:0]   r_a_w;
    logic [SLOT_W-1:0]    r_a_slot;
    logic                 r_a_hit;

    logic [Q15_W-1:0]     n_lvl;
    logic [SUM_W-1:0]     n_start;
    logic [WIDTH_W-1:0]   n_w;
    logic [SLOT_W-1:0]    n_slot;
    logic                 n_hit;
    logic [SUM_W-1:0]     w_sum [STOP_COUNT];

    // Stage B: numerator and denominator.
    logic                 r_b_v;
    t_div_req             r_b_req;
    t_div_req             n_req;
    logic [WIDTH_W-1:0]   w_d;

    logic w_a_ld;
    logic w_b_ld;

    assign w_b_ld  = !r_b_v || i_ready;
    assign w_a_ld  = !r_a_v || w_b_ld;
    assign o_ready = w_a_ld;
    assign o_valid = r_b_v;
    assign o_req   = r_b_req;

    always_comb begin
        if (i_level[LEVEL_W-1]) begin
            n_lvl = '0;
        end else if (i_level[Q15_W-1:0] > ONE_Q15) begin
            n_lvl = ONE_Q15;
        end else begin
            n_lvl = i_level[Q15_W-1:0];
        end

        for (int k = 0; k < STOP_COUNT; k++) begin
            if (k == 0) begin
                w_sum[k] = SUM_W'(i_width[k]);
            end else begin
                w_sum[k] = w_sum[k-1] + SUM_W'(i_width[k]);
            end
        end

        // Walk from the top so that the lowest matching segment wins.
        n_hit   = 1'b0;
        n_slot  = '0;
        n_start = '0;
        n_w     = '0;
        for (int k = STOP_COUNT - 1; k >= 0; k--) begin
            if (w_sum[k] >= SUM_W'(n_lvl)) begin
                n_hit   = 1'b1;
                n_slot  = (k == 0) ? '0 : SLOT_W'(k - 1);
                n_w     = i_width[k];
                n_start = w_sum[k] - SUM_W'(i_width[k]);
            end
        end
    end

    always_comb begin
        w_d = WIDTH_W'(SUM_W'(r_a_lvl) - r_a_start);
        n_req.tag.hit  = r_a_hit;
        n_req.tag.slot = r_a_slot;
        if ((r_a_w != '0) && (SUM_W'(r_a_lvl) > r_a_start)) begin
            // 510*d + w, rounding half up after division by 2*w.
            n_req.num = (NUM_W'(w_d) << 9) - (NUM_W'(w_d) << 1) + NUM_W'(r_a_w);
            n_req.den = {r_a_w, 1'b0};
        end else begin
            n_req.num = '0;
            n_req.den = DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_a_ld) begin
                r_a_v <= i_valid;
            end
            if (w_b_ld) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ld && i_valid) begin
            r_a_lvl   <= n_lvl;
            r_a_start <= n_start;
            r_a_w     <= n_w;
            r_a_slot  <= n_slot;
            r_a_hit   <= n_hit;
        end
        if (w_b_ld && r_a_v) begin
            r_b_req <= n_req;
        end
    end

endmodule

FILE: hw/rtl/gcm_divider.sv
`timescale 1ns / 1ps

module gcm_divider import gcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_div_req         i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [QUO_W-1:0] o_quo,
    output t_div_tag         o_tag
);

    logic [DIV_STAGES-1:0] r_v;
    logic [NUM_W-1:0]      r_rem [DIV_STAGES];
    logic [QUO_W-1:0]      r_quo [DIV_STAGES];
    logic [DEN_W-1:0]      r_den [DIV_STAGES];
    t_div_tag              r_tag [DIV_STAGES];
    logic [DIV_STAGES:0]   w_rdy;

    assign w_rdy[DIV_STAGES] = i_ready;
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic             in_v;
        logic [NUM_W-1:0] in_rem;
        logic [QUO_W-1:0] in_quo;
        logic [DEN_W-1:0] in_den;
        t_div_tag         in_tag;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;
        logic [NUM_W-1:0] w_dsh;

        if (k == 0) begin : g_first
            assign in_v   = i_valid;
            assign in_rem = i_req.num;
            assign in_quo = '0;
            assign in_den = i_req.den;
            assign in_tag = i_req.tag;
        end else begin : g_next
            assign in_v   = r_v[k-1];
            assign in_rem = r_rem[k-1];
            assign in_quo = r_quo[k-1];
            assign in_den = r_den[k-1];
            assign in_tag = r_tag[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // Restoring division, two quotient bits per stage, MSB first.
        always_comb begin
            n_rem = in_rem;
            n_quo = in_quo;
            w_dsh = '0;
            for (int b = 0; b < DIV_STEP; b++) begin
                w_dsh = NUM_W'(in_den) << (QUO_W - 1 - k * DIV_STEP - b);
                if (n_rem >= w_dsh) begin
                    n_rem = n_rem - w_dsh;
                    n_quo[QUO_W - 1 - k * DIV_STEP - b] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && in_v) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= in_den;
                r_tag[k] <= in_tag;
            end
        end
    end

endmodule

FILE: hw/rtl/gcm_blend.sv
`timescale 1ns / 1ps

module gcm_blend import gcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [QUO_W-1:0]  i_factor,
    input  t_div_tag          i_tag,
    input  t_colour_arr       i_colour,
    output logic              o_valid,
    input  logic              i_ready,
    output t_pixel            o_pixel,
    output logic              o_written
);

    // Stage P: per-channel products with rounding constant.
    logic          r_p_v;
    logic          r_p_hit;
    logic [15:0]   r_p1 [CHANNEL_COUNT];
    logic [15:0]   r_p2 [CHANNEL_COUNT];
    logic [15:0]   n_p1 [CHANNEL_COUNT];
    logic [15:0]   n_p2 [CHANNEL_COUNT];

    // Stage O: output register.
    logic          r_o_v;
    logic          r_o_hit;
    t_pixel        r_o_pix;
    t_pixel        n_pix;

    logic [SLOT_W-1:0] w_x2;
    logic [CHAN_W-1:0] w_inv;
    logic w_p_ld;
    logic w_o_ld;

    assign w_o_ld    = !r_o_v || i_ready;
    assign w_p_ld    = !r_p_v || w_o_ld;
    assign o_ready   = w_p_ld;
    assign o_valid   = r_o_v;
    assign o_pixel   = r_o_pix;
    assign o_written = r_o_hit;

    assign w_x2  = SLOT_W'(i_tag.slot + 1'b1);
    assign w_inv = BYTE_MAX - i_factor;

    always_comb begin
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            n_p1[ch] = 16'(i_colour[i_tag.slot][ch*CHAN_W +: CHAN_W]) * 16'(w_inv)
                     + HALF_ROUND;
            n_p2[ch] = 16'(i_colour[w_x2][ch*CHAN_W +: CHAN_W]) * 16'(i_factor)
                     + HALF_ROUND;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            if (r_p_hit) begin
                n_pix[ch] = CHAN_W'(r_p1[ch][15:8] + r_p2[ch][15:8]);
            end else begin
                n_pix[ch] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_p_ld) begin
                r_p_v <= i_valid;
            end
            if (w_o_ld) begin
                r_o_v <= r_p_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_ld && i_valid) begin
            r_p_hit <= i_tag.hit;
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                r_p1[ch] <= n_p1[ch];
                r_p2[ch] <= n_p2[ch];
            end
        end
        if (w_o_ld && r_p_v) begin
            r_o_hit <= r_p_hit;
            r_o_pix <= n_pix;
        end
    end

endmodule

FILE: hw/rtl/gradient_colour_map_unit.sv
`timescale 1ns / 1ps

// Gradient colour map. Each input beat carries one Q1.15 intensity (17-bit
// two's complement, clamped to 0..1.0) and produces exactly one output beat:
// four 8-bit channel bytes blended between two adjacent gradient stops, plus
// a flag that is low when the intensity lies beyond the sum of all segment
// widths (the channels are then zero). The unit is a fully pipelined datapath
// of eight register stages: two for clamping, the segment search and the
// divider operands, four for the radix-4 restoring divider that forms the
// blend factor, and two for the channel products and the final sum. A new
// beat is accepted every cycle while the output is not stalled. Every stage
// holds its own valid bit, so a stall at the output fills the pipeline
// bubble by bubble before the input deasserts ready. Stop colours and segment
// widths are written through the configuration channel, which is always
// ready; writes must happen only while no beat is in flight, because the
// stages read the registers directly.

module gradient_colour_map_unit import gcm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [LEVEL_W-1:0]  i_level,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [CHAN_W-1:0]          o_chan_zero,
    output logic [CHAN_W-1:0]          o_chan_one,
    output logic [CHAN_W-1:0]          o_chan_two,
    output logic [CHAN_W-1:0]          o_chan_three,
    output logic                       o_pixel_written,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [COLOUR_W-1:0]        i_cfg_data
);

    t_colour_arr r_colour;
    t_width_arr  r_width;

    // Inter-stage handshakes.
    logic     w_sel_valid;
    logic     w_sel_ready;
    t_div_req w_sel_req;

    logic             w_div_valid;
    logic             w_div_ready;
    logic [QUO_W-1:0] w_div_quo;
    t_div_tag         w_div_tag;

    t_pixel w_pixel;

    assign o_cfg_ready = 1'b1;

    // Register file. Colours and widths are kept for all four slots; only the
    // first STOP_COUNT take part in the mapping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour[0] <= 32'h0000_0000;
            r_colour[1] <= 32'h7F00_00FF;
            r_colour[2] <= 32'hFF00_FFFF;
            r_colour[3] <= 32'hFFFF_FFFF;
            r_width[0]  <= 16'd8192;
            r_width[1]  <= 16'd8192;
            r_width[2]  <= 16'd8192;
            r_width[3]  <= 16'd8192;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COLOUR_A: r_colour[0] <= i_cfg_data;
                CFG_COLOUR_B: r_colour[1] <= i_cfg_data;
                CFG_COLOUR_C: r_colour[2] <= i_cfg_data;
                CFG_COLOUR_D: r_colour[3] <= i_cfg_data;
                CFG_WIDTH_A:  r_width[0]  <= i_cfg_data[WIDTH_W-1:0];
                CFG_WIDTH_B:  r_width[1]  <= i_cfg_data[WIDTH_W-1:0];
                CFG_WIDTH_C:  r_width[2]  <= i_cfg_data[WIDTH_W-1:0];
                CFG_WIDTH_D:  r_width[3]  <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    gcm_seg_select u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_level (i_level),
        .i_width (r_width),
        .o_valid (w_sel_valid),
        .i_ready (w_sel_ready),
        .o_req   (w_sel_req)
    );

    gcm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sel_valid),
        .o_ready (w_sel_ready),
        .i_req   (w_sel_req),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_quo   (w_div_quo),
        .o_tag   (w_div_tag)
    );

    gcm_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_div_valid),
        .o_ready   (w_div_ready),
        .i_factor  (w_div_quo),
        .i_tag     (w_div_tag),
        .i_colour  (r_colour),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pixel   (w_pixel),
        .o_written (o_pixel_written)
    );

    // Channels beyond CHANNEL_COUNT read as zero.
    assign o_chan_zero  = w_pixel[0];
    assign o_chan_one   = (CHANNEL_COUNT > 1) ? w_pixel[(CHANNEL_COUNT > 1) ? 1 : 0] : '0;
    assign o_chan_two   = (CHANNEL_COUNT > 2) ? w_pixel[(CHANNEL_COUNT > 2) ? 2 : 0] : '0;
    assign o_chan_three = (CHANNEL_COUNT > 3) ? w_pixel[(CHANNEL_COUNT > 3) ? 3 : 0] : '0;

endmodule

FILE: hw/rtl/gcm_checker.sv
`timescale 1ns / 1ps

module gcm_checker import gcm_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [CHAN_W-1:0]         o_chan_zero,
    input logic [CHAN_W-1:0]         o_chan_one,
    input logic [CHAN_W-1:0]         o_chan_two,
    input logic [CHAN_W-1:0]         o_chan_three,
    input logic                      o_pixel_written
);

    // Beats accepted but not yet delivered.
    logic [$clog2(PIPE_DEPTH+1)-1:0] r_cnt;
    logic [$clog2(PIPE_DEPTH+1)-1:0] n_cnt;
    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc && !w_out_acc) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_in_acc && w_out_acc) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid
            && $stable({o_chan_zero, o_chan_one, o_chan_two, o_chan_three, o_pixel_written}))
        else $error("output beat changed while stalled");

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_written |-> o_chan_zero == '0 && o_chan_one == '0
            && o_chan_two == '0 && o_chan_three == '0)
        else $error("unwritten pixel carries nonzero channels");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PIPE_DEPTH)
        else $error("more beats in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("output beat without a matching input beat");

endmodule

bind gradient_colour_map_unit gcm_checker u_gcm_checker (.*);

FILE: tb/gradient_colour_map_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the gradient colour map. A small scoreboard keeps
// its own copy of the stop colours and segment widths, predicts the pixel for
// every accepted level beat and compares every output beat against the oldest
// prediction. The level sender works in bursts with random gaps, and the
// pixel receiver stalls on a run-length pattern of its own. One or two long
// receive hold-offs push the pipeline full so that the input backs up.
module gradient_colour_map_unit_tb;
    import gcm_pkg::*;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int HOLDOFF_CYCLES  = 80;
    localparam int IDLE_LIMIT      = 2000;
    localparam int MAX_REPORTS     = 10;

    // Shapes of gradient used by the random phases.
    typedef enum int {
        GRAD_SPREAD,
        GRAD_FULL,
        GRAD_OVERSIZE,
        GRAD_TINY,
        GRAD_GAPPED,
        GRAD_FLAT
    } t_grad_style;

    // One pixel as it leaves the block, tagged with the level that made it.
    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        t_pixel                    chan;
        logic                      written;
    } t_map_pixel;

    // Levels around the reset gradient: clamp limits on both sides, every
    // segment boundary and the middles of the first two segments.
    localparam logic signed [LEVEL_W-1:0] RESET_LEVELS [15] = '{
        17'h10000, 17'h1FFFF, 17'h00000, 17'h00001, 17'h01000,
        17'h01FFF, 17'h02000, 17'h02001, 17'h03000, 17'h04000,
        17'h06000, 17'h07FFF, 17'h08000, 17'h08001, 17'h0FFFF
    };

    // Levels for a gradient with zero-width first and third segments and a
    // total width of 10000: zero width hit at level 0, segment ends, and
    // levels past the end that leave the pixel unwritten.
    localparam logic signed [LEVEL_W-1:0] GAPPED_LEVELS [9] = '{
        17'd0, 17'd1, 17'd2000, 17'd4000, 17'd4001,
        17'd7000, 17'd10000, 17'd10001, 17'd32768
    };

    class colour_map_scoreboard;
        logic [COLOUR_W-1:0] stop_colour [REG_SLOTS];
        logic [WIDTH_W-1:0]  seg_width [REG_SLOTS];
        t_map_pixel          pixels_due [$];
        int                  mismatches;
        int                  pixels_checked;
        int                  blank_pixels;
        int                  levels_sent;

        function new();
            stop_colour[0] = 32'h0000_0000;
            stop_colour[1] = 32'h7F00_00FF;
            stop_colour[2] = 32'hFF00_FFFF;
            stop_colour[3] = 32'hFFFF_FFFF;
            foreach (seg_width[k])
                seg_width[k] = 16'd8192;
            mismatches     = 0;
            pixels_checked = 0;
            blank_pixels   = 0;
            levels_sent    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [COLOUR_W-1:0] data);
            if (idx <= CFG_COLOUR_D)
                stop_colour[int'(idx) - int'(CFG_COLOUR_A)] = data;
            else
                seg_width[int'(idx) - int'(CFG_WIDTH_A)] = data[WIDTH_W-1:0];
        endfunction

        // Clamp the level, walk the segments until the running width reaches
        // it, then blend the two stops around that segment.
        function t_map_pixel blend_for_level(logic signed [LEVEL_W-1:0] lv);
            t_map_pixel  px;
            int unsigned lvl;
            int unsigned run_sum;
            int unsigned seg_start;
            int unsigned w;
            int unsigned f;
            int unsigned c1;
            int unsigned c2;
            int unsigned v;
            int          i;
            int          ch;
            int          x1;
            int          x2;
            bit          found;

            px.level   = lv;
            px.chan    = '0;
            px.written = 1'b0;
            found      = 1'b0;
            run_sum    = 0;
            if (lv[LEVEL_W-1])
                lvl = 0;
            else if (lv[Q15_W-1:0] > ONE_Q15)
                lvl = ONE_Q15;
            else
                lvl = lv[Q15_W-1:0];

            for (i = 0; i < STOP_COUNT; i++) begin
                if (!found) begin
                    w = seg_width[i];
                    run_sum += w;
                    if (run_sum >= lvl) begin
                        found     = 1'b1;
                        seg_start = run_sum - w;
                        f         = 0;
                        // Half-up rounding of 255 * offset / width.
                        if (w != 0 && lvl > seg_start) begin
                            f = (2 * BYTE_MAX * (lvl - seg_start) + w) / (2 * w);
                            if (f > BYTE_MAX)
                                f = BYTE_MAX;
                        end
                        x1 = (i > 0) ? i - 1 : 0;
                        x2 = (x1 + 1 > STOP_COUNT - 1) ? STOP_COUNT - 1 : x1 + 1;
                        for (ch = 0; ch < CHANNEL_COUNT; ch++) begin
                            c1 = stop_colour[x1][CHAN_W*ch +: CHAN_W];
                            c2 = stop_colour[x2][CHAN_W*ch +: CHAN_W];
                            v  = ((c1 * (BYTE_MAX - f) + HALF_ROUND) >> 8)
                               + ((c2 * f + HALF_ROUND) >> 8);
                            px.chan[ch] = v[CHAN_W-1:0];
                        end
                        px.written = 1'b1;
                    end
                end
            end
            return px;
        endfunction

        function void note_level(logic signed [LEVEL_W-1:0] lv);
            pixels_due.push_back(blend_for_level(lv));
            levels_sent++;
        endfunction

        function void check_pixel(t_map_pixel got);
            t_map_pixel want;

            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("pixel beat with nothing expected: ch %h %h %h %h written %b",
                             got.chan[0], got.chan[1], got.chan[2], got.chan[3],
                             got.written);
                return;
            end
            want = pixels_due.pop_front();
            pixels_checked++;
            if (!want.written)
                blank_pixels++;
            if (got.chan[0] !== want.chan[0] || got.chan[1] !== want.chan[1] ||
                got.chan[2] !== want.chan[2] || got.chan[3] !== want.chan[3] ||
                got.written !== want.written) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("pixel mismatch at level %0d: expected %h %h %h %h/%b, got %h %h %h %h/%b",
                             want.level, want.chan[0], want.chan[1], want.chan[2],
                             want.chan[3], want.written, got.chan[0], got.chan[1],
                             got.chan[2], got.chan[3], got.written);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [LEVEL_W-1:0] i_level;
    logic                      o_valid;
    logic                      i_ready;
    logic [CHAN_W-1:0]         o_chan_zero;
    logic [CHAN_W-1:0]         o_chan_one;
    logic [CHAN_W-1:0]         o_chan_two;
    logic [CHAN_W-1:0]         o_chan_three;
    logic                      o_pixel_written;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [COLOUR_W-1:0]       i_cfg_data;

    colour_map_scoreboard sb;
    t_map_pixel           seen;
    logic [COLOUR_W-1:0]  next_colour [REG_SLOTS];
    logic [WIDTH_W-1:0]   next_width [REG_SLOTS];
    int                   burst_left;
    bit                   gaps_on;
    bit                   hold_req = 1'b0;
    int                   holdoffs_done = 0;
    int                   gradients_loaded = 0;
    int                   quiet_cycles = 0;

    gradient_colour_map_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_level         (i_level),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_chan_zero     (o_chan_zero),
        .o_chan_one      (o_chan_one),
        .o_chan_two      (o_chan_two),
        .o_chan_three    (o_chan_three),
        .o_pixel_written (o_pixel_written),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pixel monitor. Sampling happens at the rising edge, before the block's
    // own updates of that edge land, so the values are the ones the edge saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.level   = '0;
            seen.chan[0] = o_chan_zero;
            seen.chan[1] = o_chan_one;
            seen.chan[2] = o_chan_two;
            seen.chan[3] = o_chan_three;
            seen.written = o_pixel_written;
            sb.check_pixel(seen);
        end
    end

    // Watchdog: any beat on any channel restarts the count of quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d pixels still expected",
                     IDLE_LIMIT, sb.pixels_due.size());
            $display("gradient_colour_map_unit_tb: done, errors");
            $finish;
        end
    end

    // Pixel receiver. It alternates ready runs and stall runs; some ready
    // runs are long so that the pipeline also sees stretches of full flow.
    // When the stimulus asks for a hold-off, it drops ready for a long time
    // while the sender keeps offering levels, so the pipeline fills up.
    initial begin : pixel_receiver
        int stretch;
        bit rx_stall;

        i_ready  = 1'b0;
        rx_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                holdoffs_done++;
            end else begin
                if (rx_stall)
                    stretch = $urandom_range(1, 6);
                else if ($urandom_range(0, 3) == 0)
                    stretch = $urandom_range(60, 150);
                else
                    stretch = $urandom_range(1, 20);
                repeat (stretch) begin
                    @(negedge i_clk);
                    i_ready <= !rx_stall;
                end
                rx_stall = !rx_stall;
            end
        end
    end

    // One configuration beat. Valid stays high into the next write; the
    // caller lowers it once the whole gradient is loaded.
    task automatic write_reg(t_cfg_idx idx, logic [COLOUR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Writes all eight registers from next_colour and next_width. The unused
    // upper data bits of the width writes carry random junk, which the block
    // has to ignore.
    task automatic load_gradient();
        int          k;
        logic [31:0] junk;

        for (k = 0; k < REG_SLOTS; k++)
            write_reg(t_cfg_idx'(int'(CFG_COLOUR_A) + k), next_colour[k]);
        for (k = 0; k < REG_SLOTS; k++) begin
            junk = $urandom;
            write_reg(t_cfg_idx'(int'(CFG_WIDTH_A) + k),
                      {junk[COLOUR_W-1:WIDTH_W], next_width[k]});
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gradients_loaded++;
    endtask

    task automatic pick_gradient(t_grad_style style);
        int k;

        for (k = 0; k < REG_SLOTS; k++) begin
            next_colour[k] = $urandom;
            case (style)
                GRAD_SPREAD: begin
                    next_width[k] = ($urandom_range(0, 4) == 0) ? '0
                                  : 16'($urandom_range(1, 12000));
                end
                GRAD_FULL: begin
                    // Segments of width 1.0 each and all-zero / all-one stops.
                    next_width[k]  = ONE_Q15;
                    next_colour[k] = k[0] ? '1 : '0;
                end
                GRAD_OVERSIZE: begin
                    // Widths beyond 1.0: the running sum must not wrap.
                    if (k < 2)
                        next_width[k] = 16'($urandom_range(1, 10000));
                    else if (k == 2)
                        next_width[k] = 16'($urandom_range(32769, 65535));
                    else
                        next_width[k] = 16'hFFFF;
                end
                GRAD_TINY: begin
                    next_width[k] = 16'($urandom_range(1, 16));
                end
                GRAD_GAPPED: begin
                    next_width[k] = k[0] ? 16'($urandom_range(1, 20000)) : '0;
                end
                default: begin
                    next_width[k] = '0;
                end
            endcase
        end
    endtask

    // Random level, mostly in range and biased toward the segment ends of the
    // current gradient, with some beats outside the clamp limits.
    function automatic logic signed [LEVEL_W-1:0] random_level();
        int unsigned               pick;
        int unsigned               bound;
        int unsigned               total;
        int                        k;
        int                        j;
        logic signed [LEVEL_W-1:0] lv;

        pick  = $urandom_range(0, 15);
        total = 0;
        for (j = 0; j < STOP_COUNT; j++)
            total += sb.seg_width[j];
        if (pick < 2) begin
            lv = {1'b1, 16'($urandom)};
        end else if (pick < 4) begin
            lv = {1'b0, 16'($urandom_range(32769, 65535))};
        end else if (pick < 7) begin
            k     = $urandom_range(0, STOP_COUNT - 1);
            bound = 0;
            for (j = 0; j <= k; j++)
                bound += sb.seg_width[j];
            bound += $urandom_range(0, 2);
            if (bound > 0)
                bound--;
            if (bound > 65535)
                bound = 65535;
            lv = {1'b0, 16'(bound)};
        end else if (pick < 10) begin
            lv = {1'b0, 16'($urandom_range(0, (total > 32768) ? 32768 : total))};
        end else begin
            lv = {1'b0, 16'($urandom_range(0, 32768))};
        end
        return lv;
    endfunction

    // Sends one level beat. A new burst starts with a random gap, unless gaps
    // are off for this phase or the draw comes up zero.
    task automatic offer_level(logic signed [LEVEL_W-1:0] lv);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gaps_on && gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_level <= lv;
        do @(posedge i_clk); while (!o_ready);
        sb.note_level(lv);
    endtask

    // Stops sending and waits for every predicted pixel, then lets the
    // pipeline settle before any register is touched.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int p;
        int n;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_level     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COLOUR_A;
        i_cfg_data  = '0;
        sb          = new();
        burst_left  = 0;
        gaps_on     = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gradient first, so the reset values are checked as well.
        foreach (RESET_LEVELS[k])
            offer_level(RESET_LEVELS[k]);
        drain();

        next_colour[0] = 32'hFFFF_FFFF;
        next_colour[1] = 32'h0000_0000;
        next_colour[2] = 32'h80FF_01FE;
        next_colour[3] = 32'h1234_5678;
        next_width[0]  = 16'd0;
        next_width[1]  = 16'd4000;
        next_width[2]  = 16'd0;
        next_width[3]  = 16'd6000;
        load_gradient();
        gaps_on = 1'b1;
        foreach (GAPPED_LEVELS[k])
            offer_level(GAPPED_LEVELS[k]);
        drain();

        for (p = int'(GRAD_SPREAD); p <= int'(GRAD_FLAT); p++) begin
            pick_gradient(t_grad_style'(p));
            load_gradient();
            gaps_on = (t_grad_style'(p) != GRAD_FULL);
            if (t_grad_style'(p) == GRAD_SPREAD || t_grad_style'(p) == GRAD_OVERSIZE)
                hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                offer_level(random_level());
            drain();
        end

        $display("run covered %0d levels over %0d gradients, %0d long receive hold-offs",
                 sb.levels_sent, gradients_loaded + 1, holdoffs_done);
        $display("%0d pixels checked, %0d of them not written, %0d mismatches",
                 sb.pixels_checked, sb.blank_pixels, sb.mismatches);
        if (sb.mismatches == 0 && sb.pixels_due.size() == 0)
            $display("gradient_colour_map_unit_tb: done, clean");
        else
            $display("gradient_colour_map_unit_tb: done, errors");
        $finish;
    end

endmodule
